/* src/sfr_pkg.sv */
// Shared types and constants for the serial poll frame responder.
// Depends on nothing; every other file but sfr_ram imports it.
package sfr_pkg;

   // Default size of the status table
   localparam int TABLE_BYTES_DEF = 18;

   // Table entries cleared when the poll counter wraps
   localparam int CLEAR_LO = 16;
   localparam int CLEAR_HI = 17;

   // Poll counter
   localparam int        POLL_BITS  = 7;
   localparam logic [6:0] POLL_LIMIT = 7'd100;

   // Keepalive markers
   localparam logic [7:0] KEEP_A = 8'h55;
   localparam logic [7:0] KEEP_B = 8'hAA;

   // Configuration reset values
   localparam logic [7:0] CATEGORY_RST = 8'd0;
   localparam logic [7:0] ACK_RST      = 8'd6;
   localparam logic [7:0] NACK_RST     = 8'd21;

   // Request operations
   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Configuration register indexes
   localparam int          CSR_IDX_BITS = 2;
   localparam logic [1:0] CSR_CATEGORY = 2'd0;
   localparam logic [1:0] CSR_ACK      = 2'd1;
   localparam logic [1:0] CSR_NACK     = 2'd2;

   typedef struct packed {
      logic       operation;
      logic [7:0] frame_byte0;
      logic [7:0] frame_byte1;
      logic [7:0] frame_byte2;
      logic [7:0] frame_byte3;
      logic [4:0] table_index;
      logic [7:0] table_value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } rsp_payload_type;

   // Sequencer requests toward the table storage
   typedef struct packed {
      logic rd_en;       // read the table entry at rd_addr
      logic clear_tail;  // clear the two tail entries after the 100th poll
   } seq_ctrl_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_ACK,
      SEQ_TABLE,
      SEQ_CHECK,
      SEQ_REPLY
   } seq_state_type;

endpackage

/* src/sfr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module sfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 18
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/sfr_seq.sv */
// Response sequencer: walks the table, accumulates the checksum in one shared
// adder and counts polls. Depends on sfr_pkg.
module sfr_seq
   import sfr_pkg::*;
#(
   parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start_poll,
   input  logic                           start_reply,
   input  logic [7:0]                     reply_byte,
   input  logic [7:0]                     ack_code,
   input  logic [7:0]                     table_byte,
   output logic                           busy,
   output seq_ctrl_type                   ctrl,
   output logic [$clog2(TABLE_BYTES)-1:0] rd_addr,
   output logic                           rsp_strobe,
   output rsp_payload_type                rsp_data
);

   localparam int AW = $clog2(TABLE_BYTES);
   localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_BYTES - 1);

   seq_state_type         state_ff, state_in;
   logic [AW-1:0]         cnt_ff, cnt_in;
   logic [7:0]            sum_ff, sum_in;
   logic [7:0]            reply_ff, reply_in;
   logic [POLL_BITS-1:0]  poll_ff, poll_in;
   logic [POLL_BITS-1:0]  poll_inc;

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         poll_ff  <= '0;
      end else begin
         state_ff <= state_in;
         poll_ff  <= poll_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      sum_ff   <= sum_in;
      reply_ff <= reply_in;
   end

   assign poll_inc = poll_ff + POLL_BITS'(1);

   // Next state and outputs
   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      sum_in          = sum_ff;
      reply_in        = reply_ff;
      poll_in         = poll_ff;
      ctrl.rd_en      = 1'b0;
      ctrl.clear_tail = 1'b0;
      rd_addr         = '0;
      rsp_strobe      = 1'b0;
      rsp_data        = '0;
      case (state_ff)
         SEQ_IDLE: begin
            if (start_poll) begin
               state_in = SEQ_ACK;
            end else if (start_reply) begin
               reply_in = reply_byte;
               state_in = SEQ_REPLY;
            end
         end
         SEQ_ACK: begin
            // Send ACK, seed the checksum, fetch entry 0
            rsp_strobe = 1'b1;
            rsp_data   = '{tx_byte: ack_code, last_byte: 1'b0};
            sum_in     = ack_code;
            cnt_in     = '0;
            ctrl.rd_en = 1'b1;
            state_in   = SEQ_TABLE;
         end
         SEQ_TABLE: begin
            // Send one entry, add it in, prefetch the next
            rsp_strobe = 1'b1;
            rsp_data   = '{tx_byte: table_byte, last_byte: 1'b0};
            sum_in     = sum_ff + table_byte;
            if (cnt_ff == LAST_IDX) begin
               state_in = SEQ_CHECK;
            end else begin
               cnt_in     = cnt_ff + AW'(1);
               rd_addr    = cnt_ff + AW'(1);
               ctrl.rd_en = 1'b1;
            end
         end
         SEQ_CHECK: begin
            // Send checksum, advance the poll counter
            rsp_strobe = 1'b1;
            rsp_data   = '{tx_byte: sum_ff, last_byte: 1'b1};
            if (poll_inc == POLL_LIMIT) begin
               poll_in         = '0;
               ctrl.clear_tail = 1'b1;
            end else begin
               poll_in = poll_inc;
            end
            state_in = SEQ_IDLE;
         end
         SEQ_REPLY: begin
            rsp_strobe = 1'b1;
            rsp_data   = '{tx_byte: reply_ff, last_byte: 1'b1};
            state_in   = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != SEQ_IDLE);

   // The table walk always ends in the checksum byte
   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_TABLE && cnt_ff == LAST_IDX) |=> (state_ff == SEQ_CHECK))
      else $error("table walk did not end in checksum");

   // The counter never holds the wrap value
   a_poll_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear_tail |=> (poll_ff == '0))
      else $error("poll counter not cleared on wrap");

   // A poll start always begins with ACK
   a_poll_ack: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_IDLE && start_poll) |=> (state_ff == SEQ_ACK))
      else $error("poll did not start with ACK");

endmodule

/* src/serial_poll_frame_responder.sv */
// Poll request: first byte in the cycle after the request is taken, then
// one byte per cycle (ACK, table, checksum).
// Keepalive or reject: one byte in the cycle after the request is taken.
// Table write: stored at the accepting edge, does not raise busy.
// Byte rate is set by the single table read port; the receiver cannot stall.
// Synchronous reset restores the configuration reset values and clears the table valid bits and poll counter.
module serial_poll_frame_responder
   import sfr_pkg::*;
#(
   parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  req_payload_type         req_data,
   output logic                    rsp_strobe,
   output rsp_payload_type         rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [7:0]              csr_wdata
);

   localparam int AW     = $clog2(TABLE_BYTES);
   localparam int LO_IDX = CLEAR_LO % TABLE_BYTES;
   localparam int HI_IDX = CLEAR_HI % TABLE_BYTES;
   localparam bit HAS_LO = (TABLE_BYTES > CLEAR_LO);
   localparam bit HAS_HI = (TABLE_BYTES > CLEAR_HI);

   logic [7:0]             category_ff, ack_ff, nack_ff;
   logic [TABLE_BYTES-1:0] valid_ff, valid_in;
   logic                   rd_valid_ff;
   logic                   accept;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [7:0]             check;
   logic                   is_poll, is_keep;
   logic                   start_poll, start_reply;
   logic [7:0]             reply_byte;
   logic [7:0]             rd_data;
   logic [7:0]             table_byte;
   logic [AW-1:0]          rd_addr;
   seq_ctrl_type           ctrl;

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         category_ff <= CATEGORY_RST;
         ack_ff      <= ACK_RST;
         nack_ff     <= NACK_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CATEGORY: category_ff <= csr_wdata;
            CSR_ACK:      ack_ff      <= csr_wdata;
            CSR_NACK:     nack_ff     <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // Classify the frame
   assign check   = req_data.frame_byte0 + req_data.frame_byte1 + req_data.frame_byte2;
   assign is_poll = (req_data.frame_byte1 == category_ff) && (req_data.frame_byte3 == check);
   assign is_keep = ((req_data.frame_byte1 == KEEP_A) && (req_data.frame_byte3 == KEEP_B))
                 || ((req_data.frame_byte1 == KEEP_B) && (req_data.frame_byte3 == KEEP_A));

   assign start_poll  = accept && (req_data.operation == OP_FRAME) && is_poll;
   assign start_reply = accept && (req_data.operation == OP_FRAME) && !is_poll;
   assign reply_byte  = is_keep ? ack_ff : nack_ff;

   // Table write
   assign wr_en   = accept && (req_data.operation == OP_WRITE)
                 && (int'(req_data.table_index) < TABLE_BYTES);
   assign wr_addr = AW'(req_data.table_index);

   // Entry valid bits: set on write, cleared by reset; the two tail entries also on counter wrap
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (ctrl.clear_tail && HAS_LO) begin
         valid_in[LO_IDX] = 1'b0;
      end
      if (ctrl.clear_tail && HAS_HI) begin
         valid_in[HI_IDX] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Track validity of the entry being read
   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign table_byte = rd_valid_ff ? rd_data : 8'd0;

   sfr_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_BYTES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.table_value),
      .rd_en   (ctrl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sfr_seq #(
      .TABLE_BYTES (TABLE_BYTES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start_poll  (start_poll),
      .start_reply (start_reply),
      .reply_byte  (reply_byte),
      .ack_code    (ack_ff),
      .table_byte  (table_byte),
      .busy        (busy),
      .ctrl        (ctrl),
      .rd_addr     (rd_addr),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

   // Results only come out while a transaction is in progress
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result outside a transaction");

   // The final byte closes the transaction
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_byte) |=> !busy)
      else $error("busy after final byte");

   // A table write produces no result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.operation == OP_WRITE) |=> !rsp_strobe)
      else $error("result after table write");

endmodule

/* verif/tb_serial_poll_frame_responder.sv */
// Self-checking testbench for serial_poll_frame_responder: directed rows, then random phases.
// Predicts every response byte but the typed-in ones from its own copy of the table, poll counter and settings.
// Depends on sfr_pkg and the responder RTL only.
module tb_serial_poll_frame_responder;
   import sfr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         TABLE_LEN      = TABLE_BYTES_DEF;
   localparam int         DRAIN_CYCLES   = 4;
   localparam int         TAIL_CYCLES    = 30;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         DIRECTED_ROWS  = 24;
   localparam int         RANDOM_PHASES  = 6;
   localparam int         PHASE_ITEMS    = 73;
   localparam int         REQ_BITS       = $bits(req_payload_type);
   // register index past the end of the register list
   localparam logic [1:0] CSR_SPARE      = 2'd3;

   typedef enum logic [1:0] {ROW_FRAME, ROW_WRITE, ROW_CSR} row_kind_type;

   // Frame rows: a..d are the frame bytes. Write rows: a is the table index,
   // b the value. Register rows: a is the index, b the data.
   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   a;
      logic [7:0]   b;
      logic [7:0]   c;
      logic [7:0]   d;
      logic         pinned;
      logic [7:0]   pin_byte;
   } stim_row_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    start      = 1'b0;
   logic                    busy;
   req_payload_type         req_data   = '0;
   logic                    rsp_strobe;
   rsp_payload_type         rsp_data;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index  = '0;
   logic [7:0]              csr_wdata  = '0;

   // Typed-in single-byte answer that travels with a directed frame
   logic                    pin_valid  = 1'b0;
   rsp_payload_type         pin_result = '0;

   // Predictor state
   logic [7:0]              status_bytes [TABLE_LEN];
   logic [6:0]              poll_total;
   logic [7:0]              category_reg;
   logic [7:0]              ack_reg;
   logic [7:0]              nack_reg;

   rsp_payload_type         expected_bytes [$];
   rsp_payload_type         head_byte;
   int                      fail_count     = 0;
   int                      quiet_cycles   = 0;

   serial_poll_frame_responder u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Work out the response bytes of one accepted request and advance the state
   task automatic predict_request(input req_payload_type rq);
      logic [7:0] frame_sum;
      logic [7:0] check_sum;
      if (rq.operation == OP_WRITE) begin
         if (rq.table_index < TABLE_LEN)
            status_bytes[rq.table_index] = rq.table_value;
         return;
      end
      frame_sum = rq.frame_byte0 + rq.frame_byte1 + rq.frame_byte2;
      if (rq.frame_byte1 == category_reg && rq.frame_byte3 == frame_sum) begin
         check_sum = ack_reg;
         expected_bytes.push_back('{tx_byte: ack_reg, last_byte: 1'b0});
         for (int i = 0; i < TABLE_LEN; i++) begin
            check_sum = check_sum + status_bytes[i];
            expected_bytes.push_back('{tx_byte: status_bytes[i], last_byte: 1'b0});
         end
         expected_bytes.push_back('{tx_byte: check_sum, last_byte: 1'b1});
         // advance the poll counter; on wrap drop the two tail entries
         poll_total = poll_total + 7'd1;
         if (poll_total == POLL_LIMIT) begin
            poll_total = '0;
            if (CLEAR_LO < TABLE_LEN) status_bytes[CLEAR_LO] = '0;
            if (CLEAR_HI < TABLE_LEN) status_bytes[CLEAR_HI] = '0;
         end
      end else if ((rq.frame_byte1 == KEEP_A && rq.frame_byte3 == KEEP_B) ||
                   (rq.frame_byte1 == KEEP_B && rq.frame_byte3 == KEEP_A)) begin
         expected_bytes.push_back('{tx_byte: ack_reg, last_byte: 1'b1});
      end else begin
         expected_bytes.push_back('{tx_byte: nack_reg, last_byte: 1'b1});
      end
   endtask

   // Check responses, follow register writes and requests, run the watchdog
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_LEN; i++) status_bytes[i] = '0;
         poll_total   = '0;
         category_reg = CATEGORY_RST;
         ack_reg      = ACK_RST;
         nack_reg     = NACK_RST;
      end else begin
         if (rsp_strobe) begin
            if (expected_bytes.size() == 0) begin
               $error("rsp transaction with none expected: tx_byte %02h last_byte %0b",
                      rsp_data.tx_byte, rsp_data.last_byte);
               fail_count++;
            end else begin
               head_byte = expected_bytes.pop_front();
               if (rsp_data.tx_byte !== head_byte.tx_byte) begin
                  $error("tx_byte: expected %02h, actual %02h",
                         head_byte.tx_byte, rsp_data.tx_byte);
                  fail_count++;
               end
               if (rsp_data.last_byte !== head_byte.last_byte) begin
                  $error("last_byte: expected %0b, actual %0b",
                         head_byte.last_byte, rsp_data.last_byte);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CATEGORY: category_reg = csr_wdata;
               CSR_ACK:      ack_reg      = csr_wdata;
               CSR_NACK:     nack_reg     = csr_wdata;
               default:      ;
            endcase
         end
         if (start && !busy) begin
            if (pin_valid) expected_bytes.push_back(pin_result);
            else predict_request(req_data);
         end
         // end the run when nothing moves for too long
         if (rsp_strobe || (csr_valid && csr_ready) || (start && !busy))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Present one request and hold it until the block takes it
   task automatic send_request(input req_payload_type rq, input logic pinned,
                               input logic [7:0] pin_byte);
      start      <= 1'b1;
      req_data   <= rq;
      csr_valid  <= 1'b0;
      pin_valid  <= pinned;
      pin_result <= '{tx_byte: pin_byte, last_byte: 1'b1};
      do @(posedge clock); while (busy);
   endtask

   // Write one register; the caller lowers valid afterwards
   task automatic write_csr(input logic [1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic idle_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off until every expected byte has come, then let the block settle
   task automatic wait_drained();
      start     <= 1'b0;
      csr_valid <= 1'b0;
      @(posedge clock);
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Directed rows: expected bytes typed in for single-byte answers only
   function automatic stim_row_type directed_row(input int n);
      stim_row_type row;
      case (n)
         0:  row = '{ROW_FRAME, 8'h01, 8'h02, 8'h03, 8'h00, 1'b1, NACK_RST};
         1:  row = '{ROW_FRAME, 8'h00, KEEP_A, 8'h00, KEEP_B, 1'b1, ACK_RST};
         2:  row = '{ROW_FRAME, 8'h00, KEEP_B, 8'h00, KEEP_A, 1'b1, ACK_RST};
         3:  row = '{ROW_FRAME, 8'h00, KEEP_A, 8'h00, KEEP_A, 1'b1, NACK_RST};
         4:  row = '{ROW_FRAME, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00};
         5:  row = '{ROW_FRAME, 8'h00, 8'h00, 8'h00, 8'h01, 1'b1, NACK_RST};
         6:  row = '{ROW_WRITE, 8'd0,  8'hFF, 8'h00, 8'h00, 1'b0, 8'h00};
         7:  row = '{ROW_WRITE, 8'd16, 8'h7F, 8'h00, 8'h00, 1'b0, 8'h00};
         8:  row = '{ROW_WRITE, 8'd17, 8'h80, 8'h00, 8'h00, 1'b0, 8'h00};
         9:  row = '{ROW_WRITE, 8'd18, 8'h33, 8'h00, 8'h00, 1'b0, 8'h00};
         10: row = '{ROW_WRITE, 8'd31, 8'hAA, 8'h00, 8'h00, 1'b0, 8'h00};
         11: row = '{ROW_FRAME, 8'hFF, 8'h00, 8'hFF, 8'hFE, 1'b0, 8'h00};
         12: row = '{ROW_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, NACK_RST};
         13: row = '{ROW_CSR, {6'd0, CSR_ACK},      8'hFF, 8'h00, 8'h00, 1'b0, 8'h00};
         14: row = '{ROW_CSR, {6'd0, CSR_NACK},     8'h00, 8'h00, 8'h00, 1'b0, 8'h00};
         15: row = '{ROW_CSR, {6'd0, CSR_CATEGORY}, KEEP_A, 8'h00, 8'h00, 1'b0, 8'h00};
         // a poll whose marker bytes also look like a keepalive
         16: row = '{ROW_FRAME, 8'h55, KEEP_A, 8'h00, KEEP_B, 1'b0, 8'h00};
         17: row = '{ROW_FRAME, 8'h00, KEEP_B, 8'h00, KEEP_A, 1'b1, 8'hFF};
         18: row = '{ROW_FRAME, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00};
         19: row = '{ROW_CSR, {6'd0, CSR_SPARE},    8'h5A, 8'h00, 8'h00, 1'b0, 8'h00};
         20: row = '{ROW_CSR, {6'd0, CSR_CATEGORY}, 8'hFF, 8'h00, 8'h00, 1'b0, 8'h00};
         21: row = '{ROW_FRAME, 8'h01, 8'hFF, 8'h00, 8'h00, 1'b0, 8'h00};
         22: row = '{ROW_FRAME, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b1, 8'h00};
         default: row = '{ROW_CSR, {6'd0, CSR_NACK}, 8'hFF, 8'h00, 8'h00, 1'b0, 8'h00};
      endcase
      return row;
   endfunction

   function automatic req_payload_type row_request(input stim_row_type row);
      req_payload_type rq;
      if (row.kind == ROW_WRITE) begin
         rq = '{OP_WRITE, row.b, row.b, row.b, row.b, row.a[4:0], row.b};
      end else begin
         // pad the unused fields from the frame bytes
         rq = '{OP_FRAME, row.a, row.b, row.c, row.d, row.a[4:0], row.c};
      end
      return rq;
   endfunction

   // Well-formed polls most often, with keepalives, table writes and noise mixed in
   function automatic req_payload_type random_request(input logic [7:0] category);
      req_payload_type rq;
      int              pick;
      rq   = REQ_BITS'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      rq.operation = OP_FRAME;
      if (pick < 45) begin
         rq.frame_byte1 = category;
         rq.frame_byte3 = rq.frame_byte0 + rq.frame_byte1 + rq.frame_byte2;
      end else if (pick < 58) begin
         if ($urandom_range(0, 1)) begin
            rq.frame_byte1 = KEEP_A;
            rq.frame_byte3 = KEEP_B;
         end else begin
            rq.frame_byte1 = KEEP_B;
            rq.frame_byte3 = KEEP_A;
         end
      end else if (pick < 73) begin
         rq.operation   = OP_WRITE;
         rq.table_index = 5'(($urandom_range(0, 99) < 85) ? $urandom_range(0, TABLE_LEN - 1)
                                                          : $urandom_range(TABLE_LEN, 31));
      end else if (pick < 81) begin
         // right category, broken checksum
         rq.frame_byte1 = category;
         rq.frame_byte3 = rq.frame_byte0 + rq.frame_byte1 + rq.frame_byte2
                          + 8'($urandom_range(1, 255));
      end else begin
         rq.operation = 1'($urandom_range(0, 1));
      end
      return rq;
   endfunction

   initial begin
      stim_row_type row;
      logic [7:0]   category;
      logic [7:0]   ack_byte;
      logic [7:0]   nack_byte;
      int           idle_pct;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         row = directed_row(n);
         if (row.kind == ROW_CSR) begin
            wait_drained();
            write_csr(row.a[1:0], row.b);
         end else begin
            send_request(row_request(row), row.pinned, row.pin_byte);
         end
      end

      // random phases, each with its own register settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         category  = 8'($urandom);
         ack_byte  = 8'($urandom);
         nack_byte = 8'($urandom);
         case (phase)
            0: begin category = 8'h00; idle_pct = 30; end
            1: begin category = 8'hFF; ack_byte = 8'h00; nack_byte = 8'hFF; idle_pct = 0; end
            2: begin category = KEEP_A; ack_byte = 8'hFF; nack_byte = 8'h00; idle_pct = 40; end
            3: begin category = KEEP_B; idle_pct = 20; end
            4: idle_pct = 30;
            default: idle_pct = 0;
         endcase
         wait_drained();
         write_csr(CSR_CATEGORY, category);
         write_csr(CSR_ACK, ack_byte);
         write_csr(CSR_NACK, nack_byte);
         if (phase == 4) write_csr(CSR_SPARE, 8'($urandom));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_request(random_request(category), 1'b0, 8'h00);
            if ($urandom_range(1, 100) <= idle_pct) idle_sender($urandom_range(1, 14));
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
